// ===== hdl/gww_pkg.sv =====
// Shared constants and types for the greedy word wrap unit.
`timescale 1ns / 1ps
`default_nettype none
package gww_pkg;

	localparam int MAX_WIDTH = 63;
	localparam int CHAR_W    = 8;
	localparam int COL_W     = 6;
	localparam int LINE_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 2'd1;

	localparam logic [COL_W-1:0]  LINE_WIDTH_RST = 6'd63;
	localparam logic [LINE_W-1:0] LINE_LIMIT_RST = 16'hFFFF;
	localparam logic [LINE_W-1:0] LINE_MAX       = 16'hFFFF;

	typedef struct packed {
		logic [COL_W-1:0]  width;
		logic [LINE_W-1:0] limit;
	} cfg_t;

endpackage
`default_nettype wire

// ===== hdl/gww_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module gww_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/gww_alu.sv =====
// Shared add-and-compare unit: (a + b) >= lim.
`timescale 1ns / 1ps
`default_nettype none
module gww_alu (
	input  wire logic [gww_pkg::COL_W-1:0] a,
	input  wire logic [gww_pkg::COL_W-1:0] b,
	input  wire logic [gww_pkg::COL_W-1:0] lim,
	output logic                           ge
);

	logic [gww_pkg::COL_W:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};
	assign ge  = sum >= {1'b0, lim};

endmodule
`default_nettype wire

// ===== hdl/gww_ctrl.sv =====
// Layout sequencer: word buffering, line/column tracking and result register.
`timescale 1ns / 1ps
`default_nettype none
module gww_ctrl #(
	parameter int MAX_WIDTH = gww_pkg::MAX_WIDTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire gww_pkg::cfg_t                    cfg,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [gww_pkg::CHAR_W-1:0]       char_in,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [gww_pkg::CHAR_W-1:0]       out_char,
	output logic      [gww_pkg::LINE_W-1:0]       out_line,
	output logic      [gww_pkg::COL_W-1:0]        out_column,
	output logic                                  last,
	output logic                                  ram_we,
	output logic      [$clog2(MAX_WIDTH)-1:0]     ram_waddr,
	output logic      [gww_pkg::CHAR_W-1:0]       ram_wdata,
	output logic      [$clog2(MAX_WIDTH)-1:0]     ram_raddr,
	input  wire logic [gww_pkg::CHAR_W-1:0]       ram_rdata
);

	localparam int AW = $clog2(MAX_WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_READ,
		S_EMIT,
		S_SPACE,
		S_END
	} state_t;

	state_t                       state_q;
	logic [gww_pkg::COL_W-1:0]    wl_q;
	logic [gww_pkg::COL_W-1:0]    col_q;
	logic [gww_pkg::LINE_W-1:0]   line_q;
	logic [gww_pkg::COL_W-1:0]    idx_q;
	logic [gww_pkg::COL_W-1:0]    len_q;
	logic                         is_nl_q;
	logic                         out_valid_q;
	logic [gww_pkg::CHAR_W-1:0]   out_char_q;
	logic [gww_pkg::LINE_W-1:0]   out_line_q;
	logic [gww_pkg::COL_W-1:0]    out_col_q;
	logic                         last_q;

	logic [gww_pkg::COL_W-1:0]    alu_a;
	logic [gww_pkg::COL_W-1:0]    alu_b;
	logic                         alu_ge;
	logic [gww_pkg::COL_W-1:0]    len_c;
	logic [gww_pkg::LINE_W-1:0]   line_inc;
	logic                         active;
	logic                         slot_free;
	logic                         is_sep;
	logic                         word_end;
	logic                         place_now;

	assign active    = line_q < cfg.limit;
	assign slot_free = !out_valid_q || out_ready;
	assign is_sep    = (char_in == gww_pkg::CHAR_SPACE) || (char_in == gww_pkg::CHAR_NL);
	assign len_c     = (wl_q < cfg.width) ? wl_q : cfg.width;
	assign line_inc  = (line_q == gww_pkg::LINE_MAX) ? line_q : line_q + 1'b1;
	assign word_end  = idx_q == len_q - 1'b1;
	assign place_now = slot_free && ((state_q == S_EMIT) ||
		(state_q == S_SPACE && !is_nl_q && !alu_ge && active));

	always_comb begin
		alu_a = col_q;
		alu_b = '0;
		case (state_q)
			S_IDLE: begin
				alu_a = wl_q;
			end
			S_CHECK: begin
				alu_b = len_c;
			end
			S_EMIT: begin
				alu_b = gww_pkg::COL_W'(1);
			end
			default: begin
				alu_b = '0;
			end
		endcase
	end

	gww_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.lim (cfg.width),
		.ge  (alu_ge)
	);

	assign in_ready  = state_q == S_IDLE;
	assign ram_we    = in_ready && in_valid && active && !is_sep && !alu_ge;
	assign ram_waddr = wl_q[AW-1:0];
	assign ram_wdata = char_in;
	assign ram_raddr = idx_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wl_q        <= '0;
			col_q       <= '0;
			line_q      <= '0;
			idx_q       <= '0;
			len_q       <= '0;
			is_nl_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_line_q  <= '0;
			out_col_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			if (place_now) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && active) begin
						if (!is_sep) begin
							if (!alu_ge) begin
								wl_q <= wl_q + 1'b1;
							end
						end else begin
							is_nl_q <= char_in == gww_pkg::CHAR_NL;
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (wl_q == '0) begin
						state_q <= S_SPACE;
					end else begin
						len_q   <= len_c;
						idx_q   <= '0;
						state_q <= S_READ;
						if (alu_ge) begin
							line_q <= line_inc;
							col_q  <= '0;
						end
					end
				end
				S_READ: begin
					if (!active) begin
						wl_q    <= '0;
						state_q <= S_SPACE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						out_char_q  <= ram_rdata;
						out_line_q  <= line_q;
						out_col_q   <= col_q;
						last_q      <= word_end && (is_nl_q || alu_ge);
						col_q       <= col_q + 1'b1;
						if (word_end) begin
							wl_q    <= '0;
							state_q <= S_SPACE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				S_SPACE: begin
					if (is_nl_q) begin
						line_q  <= line_inc;
						col_q   <= '0;
						state_q <= S_END;
					end else if (!alu_ge && active) begin
						if (slot_free) begin
							out_char_q  <= gww_pkg::CHAR_SPACE;
							out_line_q  <= line_q;
							out_col_q   <= col_q;
							last_q      <= 1'b1;
							col_q       <= col_q + 1'b1;
							state_q     <= S_END;
						end
					end else begin
						state_q <= S_END;
					end
				end
				S_END: begin
					if (alu_ge) begin
						line_q <= line_inc;
						col_q  <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign out_line   = out_line_q;
	assign out_column = out_col_q;
	assign last       = last_q;

endmodule
`default_nettype wire

// ===== hdl/greedy_word_wrap_unit.sv =====
// Top level of the greedy word wrap unit: configuration registers, word RAM and sequencer.
// Text bytes enter one at a time. A word byte is written into the word RAM, bytes past the
// line width are dropped, and the unit stays ready for the next byte. A space or newline
// starts the layout sequencer, which drives one shared add-and-compare unit and reads the
// word RAM one byte at a time: each placed character takes a read state, for the
// registered RAM read, and then an emit state, and the result register may wait for
// out_ready before each placement. Input is not accepted while the sequencer runs. Each
// result carries the character, its line and column, and last marks the final placement
// for a byte. Configuration writes are always accepted and must be made only while the
// unit is idle.
`timescale 1ns / 1ps
`default_nettype none
module greedy_word_wrap_unit #(
	parameter int MAX_WIDTH = gww_pkg::MAX_WIDTH
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [gww_pkg::CHAR_W-1:0]        char_in,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic      [gww_pkg::CHAR_W-1:0]        out_char,
	output logic      [gww_pkg::LINE_W-1:0]        out_line,
	output logic      [gww_pkg::COL_W-1:0]         out_column,
	output logic                                   last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gww_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [gww_pkg::CFG_DAT_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [gww_pkg::COL_W-1:0] MAXW = gww_pkg::COL_W'(MAX_WIDTH);

	logic [gww_pkg::COL_W-1:0]  line_width_q;
	logic [gww_pkg::LINE_W-1:0] line_limit_q;
	gww_pkg::cfg_t              cfg;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [gww_pkg::CHAR_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [gww_pkg::CHAR_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= gww_pkg::LINE_WIDTH_RST;
			line_limit_q <= gww_pkg::LINE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gww_pkg::REG_LINE_WIDTH: line_width_q <= cfg_data[gww_pkg::COL_W-1:0];
				gww_pkg::REG_LINE_LIMIT: line_limit_q <= cfg_data[gww_pkg::LINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// effective width: 0 acts as 1, clamp to MAX_WIDTH
	always_comb begin
		cfg.limit = line_limit_q;
		if (line_width_q == '0) begin
			cfg.width = gww_pkg::COL_W'(1);
		end else if (line_width_q > MAXW) begin
			cfg.width = MAXW;
		end else begin
			cfg.width = line_width_q;
		end
	end

	gww_ram #(
		.WIDTH (gww_pkg::CHAR_W),
		.DEPTH (MAX_WIDTH)
	) u_word_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gww_ctrl #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.out_line   (out_line),
		.out_column (out_column),
		.last       (last),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_column < cfg.width)
		else $error("placement column beyond line width");

	a_line_active: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_line < cfg.limit)
		else $error("placement on a line past the limit");

	a_ready_no_ram_read_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> in_ready && char_in != gww_pkg::CHAR_SPACE && char_in != gww_pkg::CHAR_NL)
		else $error("word RAM written outside word byte acceptance");

endmodule
`default_nettype wire

// ===== tb/gww_placement_checker.sv =====
// Placement checker for the greedy word wrap unit: lays out each accepted byte and compares results.
`timescale 1ns / 1ps
module gww_placement_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic [gww_pkg::CHAR_W-1:0]     char_in,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [gww_pkg::CHAR_W-1:0]     out_char,
	input  wire logic [gww_pkg::LINE_W-1:0]     out_line,
	input  wire logic [gww_pkg::COL_W-1:0]      out_column,
	input  wire logic                           last,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [gww_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gww_pkg::CFG_DAT_W-1:0]  cfg_data,
	output int                                  fail_count,
	output int                                  pending,
	output logic      [gww_pkg::LINE_W-1:0]     line_now
);
	import gww_pkg::*;

	localparam int MAX_RESULTS = 64;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [LINE_W-1:0] line;
		logic [COL_W-1:0]  col;
		logic              last;
	} placement_t;

	placement_t        due_q[$];
	logic [CHAR_W-1:0] word_buf [MAX_WIDTH];
	int unsigned       word_len;
	int unsigned       col_pos;
	int unsigned       line_pos;
	int unsigned       placed;
	cfg_t              cfg;
	int                fails;

	function automatic int unsigned eff_width();
		int unsigned w;
		w = cfg.width;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	task automatic next_line();
		if (line_pos < LINE_MAX) line_pos++;
		col_pos = 0;
	endtask

	task automatic place_char(input logic [CHAR_W-1:0] ch);
		placement_t p;
		if (line_pos >= cfg.limit || placed >= MAX_RESULTS) return;
		p.ch   = ch;
		p.line = line_pos[LINE_W-1:0];
		p.col  = col_pos[COL_W-1:0];
		p.last = 1'b0;
		due_q.push_back(p);
		placed++;
		col_pos++;
	endtask

	task automatic wrap_byte(input logic [CHAR_W-1:0] ch);
		int unsigned w;
		int unsigned len;
		int unsigned i;
		placement_t  p;
		w = eff_width();
		placed = 0;
		if (line_pos >= cfg.limit) return;
		if (ch != CHAR_SPACE && ch != CHAR_NL) begin
			if (word_len < w && word_len < MAX_WIDTH) begin
				word_buf[word_len] = ch;
				word_len++;
			end
			return;
		end
		if (word_len > 0) begin
			len = (word_len < w) ? word_len : w;
			if (col_pos + len >= w) next_line();
			for (i = 0; i < len; i++) place_char(word_buf[i]);
			word_len = 0;
		end
		if (ch == CHAR_NL) next_line();
		else if (col_pos < w) place_char(CHAR_SPACE);
		if (col_pos >= w) next_line();
		if (placed > 0) begin
			p = due_q.pop_back();
			p.last = 1'b1;
			due_q.push_back(p);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			due_q.delete();
			word_len = 0;
			col_pos = 0;
			line_pos = 0;
			placed = 0;
			cfg.width = LINE_WIDTH_RST;
			cfg.limit = LINE_LIMIT_RST;
			fails = 0;
			fail_count <= 0;
			pending <= 0;
			line_now <= '0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual char %0d line %0d col %0d last %0b",
						$time, out_char, out_line, out_column, last);
					fails++;
				end else begin
					want = due_q.pop_front();
					check_field("out_char", want.ch, out_char);
					check_field("out_line", want.line, out_line);
					check_field("out_column", want.col, out_column);
					check_field("last", want.last, last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LINE_WIDTH) cfg.width = cfg_data[COL_W-1:0];
				else if (cfg_index == REG_LINE_LIMIT) cfg.limit = cfg_data[LINE_W-1:0];
			end
			if (in_valid && in_ready) wrap_byte(char_in);
			fail_count <= fails;
			pending <= due_q.size();
			line_now <= line_pos[LINE_W-1:0];
		end
	end

endmodule

// ===== tb/greedy_word_wrap_unit_tb.sv =====
// Testbench top for the greedy word wrap unit: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps
module greedy_word_wrap_unit_tb;
	import gww_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 2 * MAX_WIDTH + 8;
	localparam int CYCLE_LIMIT   = 600000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [CHAR_W-1:0]    char_in;
	logic                 out_valid;
	logic                 out_ready;
	logic [CHAR_W-1:0]    out_char;
	logic [LINE_W-1:0]    out_line;
	logic [COL_W-1:0]     out_column;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	int                   fail_count;
	int                   pending;
	logic [LINE_W-1:0]    line_now;
	int                   hold_seq;
	int                   burst_left;
	int                   items_sent;
	int                   cycles;

	greedy_word_wrap_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .char_in(char_in),
		.out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
		.out_line(out_line), .out_column(out_column), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gww_placement_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .char_in(char_in),
		.out_valid(out_valid), .out_ready(out_ready), .out_char(out_char),
		.out_line(out_line), .out_column(out_column), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .line_now(line_now)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : receiver
		int       seen;
		int       stay;
		int       held;
		rx_mode_t mode;
		seen = 0;
		stay = 0;
		mode = RX_ALWAYS;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen) begin
				seen = hold_seq;
				out_ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
			end else begin
				if (stay == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					stay = $urandom_range(8, 80);
				end
				stay--;
				case (mode)
					RX_ALWAYS: out_ready <= 1'b1;
					RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// one request per call; bursts of random length, random gaps between them
	task automatic put_byte(input logic [CHAR_W-1:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_in <= ch;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic put_string(input string s);
		foreach (s[i]) put_byte(s[i]);
	endtask

	function automatic logic [CHAR_W-1:0] rand_word_char();
		logic [CHAR_W-1:0] c;
		do c = CHAR_W'($urandom_range(0, 255)); while (c == CHAR_SPACE || c == CHAR_NL);
		return c;
	endfunction

	task automatic put_word(input int len);
		repeat (len) put_byte(rand_word_char());
	endtask

	// mostly words with separators; some stray bytes, bare separators, overlong words
	task automatic put_random_text(input int count, input int width);
		int target;
		int kind;
		target = items_sent + count;
		while (items_sent < target) begin
			kind = $urandom_range(0, 19);
			if (kind == 0) put_byte(CHAR_W'($urandom_range(0, 255)));
			else if (kind == 1) put_byte(CHAR_NL);
			else if (kind == 2) put_byte(CHAR_SPACE);
			else begin
				if (kind == 3) put_word($urandom_range(width, width + 4));
				else put_word($urandom_range(1, (width < 8) ? width : 8));
				put_byte(($urandom_range(0, 4) == 0) ? CHAR_NL : CHAR_SPACE);
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain all results, then give the sequencer time to finish silent work
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int phase_widths [6];
		int k;
		int w;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_seq = 0;
		burst_left = 0;
		items_sent = 0;
		phase_widths = '{63, 1, 62, 13, 0, 8};
		phase_widths[4] = $urandom_range(2, 61);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// width 8 with junk in the upper data bits
		write_reg(REG_LINE_WIDTH, 16'hFFC8);
		write_reg(REG_LINE_LIMIT, LINE_LIMIT_RST);
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(CHAR_SPACE);
		put_byte(CHAR_SPACE);
		put_byte(CHAR_NL);
		put_string("ABCDEFGH ");
		put_string("abcdefghij\n");
		wait_idle();

		// zero width behaves as one column
		write_reg(REG_LINE_WIDTH, 16'h0000);
		put_string("ab c\n ");
		wait_idle();

		// width shrinks under a buffered word
		write_reg(REG_LINE_WIDTH, 16'd20);
		put_word(12);
		wait_idle();
		write_reg(REG_LINE_WIDTH, 16'd5);
		put_byte(CHAR_SPACE);
		wait_idle();

		write_reg(REG_SPARE_LO, CFG_DAT_W'($urandom_range(0, 65535)));
		write_reg(REG_SPARE_HI, CFG_DAT_W'($urandom_range(0, 65535)));

		write_reg(REG_LINE_LIMIT, 16'h0000);
		put_string("xy z\n");
		wait_idle();

		// limit hit by the line advance before a word is placed
		write_reg(REG_LINE_WIDTH, 16'd6);
		write_reg(REG_LINE_LIMIT, CFG_DAT_W'(line_now + 1));
		put_string("abcd efgh ij ");
		wait_idle();
		write_reg(REG_LINE_LIMIT, LINE_LIMIT_RST);

		for (k = 0; k < 6; k++) begin
			w = phase_widths[k];
			write_reg(REG_LINE_WIDTH, CFG_DAT_W'(($urandom_range(0, 1023) << COL_W) | w));
			if (k == 3) write_reg(REG_LINE_LIMIT, CFG_DAT_W'(line_now + 3));
			if (k == 0) hold_seq <= hold_seq + 1;
			put_random_text(25, (w == 0) ? 1 : w);
			if (k == 2) wait_idle();
			put_random_text(25, (w == 0) ? 1 : w);
			wait_idle();
			if (k == 3) write_reg(REG_LINE_LIMIT, LINE_LIMIT_RST);
		end

		wait_idle();
		if (fail_count == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
